FILE: src/ffba_pkg.sv
// Shared constants and types of the first-fit block allocator.
`default_nettype none

package ffba_pkg;

    localparam int MAX_BLOCKS   = 64;
    localparam int ADDR_BITS    = 20;
    localparam int HEADER_BYTES = 16;

    localparam int IDX_W   = $clog2(MAX_BLOCKS);
    localparam int CNT_W   = $clog2(MAX_BLOCKS + 1);
    localparam int SUM_W   = ADDR_BITS + 2;
    localparam int PADDR_W = 2;
    localparam int PDATA_W = 32;

    localparam logic [PADDR_W-1:0] REG_HEAP_LIMIT = PADDR_W'(0);

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_ZERO     = 2'd1;
    localparam logic [1:0] ST_NO_SPACE = 2'd2;
    localparam logic [1:0] ST_UNKNOWN  = 2'd3;

    typedef struct packed {
        logic [ADDR_BITS-1:0] start;
        logic [ADDR_BITS-1:0] bytes;
    } t_entry;

    typedef struct packed {
        logic [ADDR_BITS-1:0] a;
        logic [ADDR_BITS-1:0] b;
        logic                 add_hdr;
        logic [ADDR_BITS-1:0] c;
    } t_cmp_op;

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic             ge;
        logic             eq;
    } t_cmp_res;

endpackage

`default_nettype wire

FILE: src/ffba_ifs.sv
// Request and response channel interfaces of the first-fit block allocator.
`default_nettype none

interface ffba_req_if;
    import ffba_pkg::*;
    logic                 valid;
    logic                 ready;
    logic                 action;
    logic [ADDR_BITS-1:0] req_bytes;
    logic [ADDR_BITS-1:0] free_addr;

    modport source (output valid, action, req_bytes, free_addr, input ready);
    modport sink (input valid, action, req_bytes, free_addr, output ready);
endinterface

interface ffba_rsp_if;
    import ffba_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [ADDR_BITS-1:0] result_addr;
    logic [1:0]           status;

    modport source (output valid, result_addr, status, input ready);
    modport sink (input valid, result_addr, status, output ready);
endinterface

`default_nettype wire

FILE: src/ffba_table_ram.sv
// Single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module ffba_table_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 40
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: src/ffba_cmp_unit.sv
// Shared add-and-compare unit: sum of two operands plus an optional header, compared to a third.
`default_nettype none

module ffba_cmp_unit (
    input  wire ffba_pkg::t_cmp_op  i_op,
    output ffba_pkg::t_cmp_res      o_res
);
    import ffba_pkg::*;

    logic [SUM_W-1:0] sum;
    logic [SUM_W-1:0] ref_val;

    always_comb begin
        sum = SUM_W'(i_op.a) + SUM_W'(i_op.b)
            + (i_op.add_hdr ? SUM_W'(HEADER_BYTES) : SUM_W'(0));
        ref_val = SUM_W'(i_op.c);
        o_res.sum = sum;
        o_res.ge  = (sum >= ref_val);
        o_res.eq  = (sum == ref_val);
    end

endmodule

`default_nettype wire

FILE: src/first_fit_block_allocator.sv
// Top level of the first-fit block allocator: sequencer, block table and configuration port.
// Zero-size allocs, null frees and empty-table frees go straight from acceptance to the result;
// other requests scan the N table entries (at most 64), except allocations on an empty table; the
// first-fit scan reads one entry per cycle through the single read port of the table RAM.
// One item at a time; the next item can be accepted the cycle after the result is taken.
// Reset (synchronous, active low) empties the table, zeroes the break, sets heap_limit to 1048575.
`default_nettype none

module first_fit_block_allocator (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    ffba_req_if.sink                             i_req,
    ffba_rsp_if.source                           o_rsp,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [ffba_pkg::PADDR_W-1:0]    paddr,
    input  wire logic [ffba_pkg::PDATA_W-1:0]    pwdata,
    output logic      [ffba_pkg::PDATA_W-1:0]    prdata,
    output logic                                 pready
);
    import ffba_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_APPEND = 3'd2;
    localparam logic [2:0] S_ADDR   = 3'd3;
    localparam logic [2:0] S_RESP   = 3'd4;

    logic [2:0]            r_state, n_state;
    logic                  r_action, n_action;
    logic [ADDR_BITS-1:0]  r_req, n_req;
    logic [ADDR_BITS-1:0]  r_faddr, n_faddr;
    logic [CNT_W-1:0]      r_idx, n_idx;
    logic                  r_dv, n_dv;
    logic [IDX_W-1:0]      r_didx, n_didx;
    logic [ADDR_BITS-1:0]  r_hit_start, n_hit_start;
    logic [MAX_BLOCKS-1:0] r_used, n_used;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [ADDR_BITS-1:0]  r_break, n_break;
    logic [ADDR_BITS-1:0]  r_heap_limit;
    logic [ADDR_BITS-1:0]  r_res_addr, n_res_addr;
    logic [1:0]            r_res_status, n_res_status;

    logic                  ram_we;
    logic [IDX_W-1:0]      ram_waddr;
    t_entry                ram_wdata;
    logic                  ram_re;
    logic [IDX_W-1:0]      ram_raddr;
    t_entry                rd_entry;
    t_cmp_op               cmp_op;
    t_cmp_res              cmp_res;
    logic                  hit;
    logic                  cfg_wr;

    ffba_table_ram #(
        .DEPTH (MAX_BLOCKS),
        .WIDTH ($bits(t_entry))
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (rd_entry)
    );

    ffba_cmp_unit u_cmp (
        .i_op  (cmp_op),
        .o_res (cmp_res)
    );

    always_comb begin
        n_state      = r_state;
        n_action     = r_action;
        n_req        = r_req;
        n_faddr      = r_faddr;
        n_idx        = r_idx;
        n_dv         = r_dv;
        n_didx       = r_didx;
        n_hit_start  = r_hit_start;
        n_used       = r_used;
        n_count      = r_count;
        n_break      = r_break;
        n_res_addr   = r_res_addr;
        n_res_status = r_res_status;

        ram_we          = 1'b0;
        ram_waddr       = r_count[IDX_W-1:0];
        ram_wdata.start = r_break;
        ram_wdata.bytes = r_req;
        ram_re          = 1'b0;
        ram_raddr       = r_idx[IDX_W-1:0];

        cmp_op.a       = rd_entry.bytes;
        cmp_op.b       = '0;
        cmp_op.add_hdr = 1'b0;
        cmp_op.c       = r_req;
        hit            = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_action     = i_req.action;
                    n_req        = i_req.req_bytes;
                    n_faddr      = i_req.free_addr;
                    n_idx        = '0;
                    n_dv         = 1'b0;
                    n_res_addr   = '0;
                    n_res_status = ST_OK;
                    if (i_req.action == ACT_ALLOC) begin
                        if (i_req.req_bytes == '0) begin
                            n_res_status = ST_ZERO;
                            n_state      = S_RESP;
                        end else if (r_count == '0) begin
                            n_state = S_APPEND;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end else begin
                        if (i_req.free_addr == '0) begin
                            n_state = S_RESP;
                        end else if (r_count == '0) begin
                            n_res_status = ST_UNKNOWN;
                            n_state      = S_RESP;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end
                end
            end
            S_SCAN: begin
                if (r_idx < r_count) begin
                    ram_re = 1'b1;
                    n_idx  = r_idx + CNT_W'(1);
                end
                n_dv   = (r_idx < r_count);
                n_didx = r_idx[IDX_W-1:0];
                if (r_action == ACT_FREE) begin
                    cmp_op.a       = rd_entry.start;
                    cmp_op.add_hdr = 1'b1;
                    cmp_op.c       = r_faddr;
                    hit            = cmp_res.eq;
                end else begin
                    hit = !r_used[r_didx] && cmp_res.ge;
                end
                if (r_dv) begin
                    if (hit) begin
                        if (r_action == ACT_FREE) begin
                            n_used[r_didx] = 1'b0;
                            n_state        = S_RESP;
                        end else begin
                            n_used[r_didx] = 1'b1;
                            n_hit_start    = rd_entry.start;
                            n_state        = S_ADDR;
                        end
                    end else if ({1'b0, r_didx} + CNT_W'(1) == r_count) begin
                        if (r_action == ACT_FREE) begin
                            n_res_status = ST_UNKNOWN;
                            n_state      = S_RESP;
                        end else begin
                            n_state = S_APPEND;
                        end
                    end
                end
            end
            S_APPEND: begin
                cmp_op.a       = r_break;
                cmp_op.b       = r_req;
                cmp_op.add_hdr = 1'b1;
                cmp_op.c       = r_heap_limit;
                if (r_count == CNT_W'(MAX_BLOCKS) || (cmp_res.ge && !cmp_res.eq)) begin
                    n_res_status = ST_NO_SPACE;
                    n_state      = S_RESP;
                end else begin
                    ram_we                       = 1'b1;
                    n_used[r_count[IDX_W-1:0]]   = 1'b1;
                    n_count                      = r_count + CNT_W'(1);
                    n_break                      = cmp_res.sum[ADDR_BITS-1:0];
                    n_hit_start                  = r_break;
                    n_state                      = S_ADDR;
                end
            end
            S_ADDR: begin
                cmp_op.a       = r_hit_start;
                cmp_op.add_hdr = 1'b1;
                n_res_addr     = cmp_res.sum[ADDR_BITS-1:0];
                n_state        = S_RESP;
            end
            S_RESP: begin
                if (o_rsp.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign cfg_wr = psel && penable && pwrite && pready && (paddr == REG_HEAP_LIMIT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_dv         <= 1'b0;
            r_used       <= '0;
            r_count      <= '0;
            r_break      <= '0;
            r_heap_limit <= '1;
        end else begin
            r_state <= n_state;
            r_dv    <= n_dv;
            r_used  <= n_used;
            r_count <= n_count;
            r_break <= n_break;
            if (cfg_wr) begin
                r_heap_limit <= pwdata[ADDR_BITS-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_action     <= n_action;
        r_req        <= n_req;
        r_faddr      <= n_faddr;
        r_idx        <= n_idx;
        r_didx       <= n_didx;
        r_hit_start  <= n_hit_start;
        r_res_addr   <= n_res_addr;
        r_res_status <= n_res_status;
    end

    assign i_req.ready       = (r_state == S_IDLE);
    assign o_rsp.valid       = (r_state == S_RESP);
    assign o_rsp.result_addr = r_res_addr;
    assign o_rsp.status      = r_res_status;

    assign pready = 1'b1;
    assign prdata = (paddr == REG_HEAP_LIMIT) ? PDATA_W'(r_heap_limit) : '0;

endmodule

`default_nettype wire

FILE: src/ffba_checker.sv
// Port-level assertions for the first-fit block allocator and their bind.
`default_nettype none

module ffba_checker (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           i_req_valid,
    input wire logic                           i_req_ready,
    input wire logic                           o_rsp_valid,
    input wire logic                           o_rsp_ready,
    input wire logic [ffba_pkg::ADDR_BITS-1:0] o_rsp_result_addr,
    input wire logic [1:0]                     o_rsp_status
);
    import ffba_pkg::*;

    // A pending result blocks new requests.
    a_no_req_with_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_req_ready && o_rsp_valid))
        else $error("request channel ready while a result word is pending");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready) |=> !i_req_ready)
        else $error("request channel still ready after accepting a word");

    a_fail_zero_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && o_rsp_status != ST_OK) |-> (o_rsp_result_addr == '0))
        else $error("failed request returned a nonzero address");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && !o_rsp_ready) |=>
            (o_rsp_valid && $stable(o_rsp_result_addr) && $stable(o_rsp_status)))
        else $error("stalled result word changed or dropped");

endmodule

bind first_fit_block_allocator ffba_checker u_ffba_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_req_valid       (i_req.valid),
    .i_req_ready       (i_req.ready),
    .o_rsp_valid       (o_rsp.valid),
    .o_rsp_ready       (o_rsp.ready),
    .o_rsp_result_addr (o_rsp.result_addr),
    .o_rsp_status      (o_rsp.status)
);

`default_nettype wire

FILE: tb/tb_first_fit_block_allocator.sv
// Self-checking testbench of the first-fit block allocator with a built-in allocation predictor.
`timescale 1ns / 100ps

module tb_first_fit_block_allocator;
    import ffba_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int LONG_STALL     = 400;
    localparam int STALL_AT       = 250;
    localparam int DRAIN_CYCLES   = 80;
    localparam int FEED_DEPTH     = 4;

    typedef struct packed {
        logic                 action;
        logic [ADDR_BITS-1:0] req_bytes;
        logic [ADDR_BITS-1:0] free_addr;
    } t_request;

    typedef struct packed {
        logic [ADDR_BITS-1:0] addr;
        logic [1:0]           status;
    } t_outcome;

    logic i_clk;
    logic i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    ffba_req_if req_ch ();
    ffba_rsp_if rsp_ch ();

    first_fit_block_allocator DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Predicted allocator state.
    logic [ADDR_BITS-1:0] blk_start [MAX_BLOCKS];
    logic [ADDR_BITS-1:0] blk_size  [MAX_BLOCKS];
    bit                   blk_used  [MAX_BLOCKS];
    int unsigned          blk_count;
    int unsigned          heap_brk;
    int unsigned          heap_limit_reg;

    t_request request_q [$];
    t_outcome outcome_q [$];

    int send_idle;
    int recv_idle;
    int fail_count;
    int results_seen;
    int requests_taken;
    int status_seen [4];
    int stall_left;
    bit long_stall_done;
    int quiet_cycles;

    t_request taken_req;
    t_request next_req;
    t_outcome want;

    wire req_fire = (req_ch.valid === 1'b1) && (req_ch.ready === 1'b1);
    wire rsp_fire = (rsp_ch.valid === 1'b1) && (rsp_ch.ready === 1'b1);

    always #6 i_clk = ~i_clk;

    function automatic t_outcome first_fit_outcome(input t_request rq);
        t_outcome    res;
        bit          hit;
        int unsigned nxt_brk;
        int          i;
        res.addr   = '0;
        res.status = ST_OK;
        hit        = 1'b0;
        if (rq.action == ACT_ALLOC) begin
            if (rq.req_bytes == 0) begin
                res.status = ST_ZERO;
            end else begin
                for (i = 0; i < blk_count; i++) begin
                    if (!hit && !blk_used[i] && blk_size[i] >= rq.req_bytes) begin
                        blk_used[i] = 1'b1;
                        res.addr    = blk_start[i] + HEADER_BYTES;
                        hit         = 1'b1;
                    end
                end
                if (!hit) begin
                    nxt_brk = heap_brk + HEADER_BYTES + rq.req_bytes;
                    if (blk_count >= MAX_BLOCKS || nxt_brk > heap_limit_reg) begin
                        res.status = ST_NO_SPACE;
                    end else begin
                        blk_start[blk_count] = heap_brk;
                        blk_size[blk_count]  = rq.req_bytes;
                        blk_used[blk_count]  = 1'b1;
                        res.addr             = heap_brk + HEADER_BYTES;
                        blk_count            = blk_count + 1;
                        heap_brk             = nxt_brk;
                    end
                end
            end
        end else if (rq.free_addr != 0) begin
            for (i = 0; i < blk_count; i++) begin
                if (!hit && (blk_start[i] + HEADER_BYTES) == rq.free_addr) begin
                    blk_used[i] = 1'b0;
                    hit         = 1'b1;
                end
            end
            if (!hit) begin
                res.status = ST_UNKNOWN;
            end
        end
        return res;
    endfunction

    // Request driver: keeps a word steady until it is taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else begin
            if (req_fire) begin
                taken_req.action    = req_ch.action;
                taken_req.req_bytes = req_ch.req_bytes;
                taken_req.free_addr = req_ch.free_addr;
                outcome_q.push_back(first_fit_outcome(taken_req));
                requests_taken++;
            end
            if (!req_ch.valid || req_fire) begin
                if (request_q.size() != 0 && $urandom_range(99) >= send_idle) begin
                    next_req = request_q.pop_front();
                    req_ch.valid     <= 1'b1;
                    req_ch.action    <= next_req.action;
                    req_ch.req_bytes <= next_req.req_bytes;
                    req_ch.free_addr <= next_req.free_addr;
                end else begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Response monitor and receiver back-pressure.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
            stall_left   <= 0;
        end else begin
            if (rsp_fire) begin
                if (outcome_q.size() == 0) begin
                    $error("unexpected word: result_addr %0h, status %0d",
                           rsp_ch.result_addr, rsp_ch.status);
                    fail_count++;
                end else begin
                    want = outcome_q.pop_front();
                    if (rsp_ch.result_addr !== want.addr) begin
                        $error("result_addr mismatch: expected %0h, actual %0h",
                               want.addr, rsp_ch.result_addr);
                        fail_count++;
                    end
                    if (rsp_ch.status !== want.status) begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, rsp_ch.status);
                        fail_count++;
                    end
                end
                status_seen[rsp_ch.status]++;
                results_seen++;
            end
            if (stall_left != 0) begin
                stall_left   <= stall_left - 1;
                rsp_ch.ready <= 1'b0;
            end else if (!long_stall_done && results_seen == STALL_AT) begin
                stall_left      <= LONG_STALL;
                long_stall_done <= 1'b1;
                rsp_ch.ready    <= 1'b0;
            end else begin
                rsp_ch.ready <= ($urandom_range(99) >= recv_idle);
            end
        end
    end

    always @(posedge i_clk) begin
        if (req_fire || rsp_fire) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic write_heap_limit(input logic [ADDR_BITS-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_HEAP_LIMIT;
        pwdata  <= PDATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        heap_limit_reg = value;
    endtask

    task automatic queue_request(input logic act, input logic [ADDR_BITS-1:0] nbytes,
                                 input logic [ADDR_BITS-1:0] faddr);
        t_request rq;
        @(negedge i_clk);
        while (request_q.size() >= FEED_DEPTH) @(negedge i_clk);
        rq.action    = act;
        rq.req_bytes = nbytes;
        rq.free_addr = faddr;
        request_q.push_back(rq);
    endtask

    task automatic wait_for_idle();
        do @(negedge i_clk);
        while (request_q.size() != 0 || req_ch.valid || outcome_q.size() != 0);
    endtask

    // Mostly small allocations and frees of payload addresses in the block table, with some noise.
    task automatic queue_random_requests(input int n);
        int                   pick;
        int                   sub;
        logic [ADDR_BITS-1:0] sz;
        logic [ADDR_BITS-1:0] fa;
        repeat (n) begin
            pick = $urandom_range(99);
            sub  = $urandom_range(99);
            sz   = ADDR_BITS'($urandom);
            fa   = ADDR_BITS'($urandom);
            if (pick < 55) begin
                if (sub < 4) begin
                    sz = '0;
                end else if (sub < 70) begin
                    sz = ADDR_BITS'($urandom_range(64, 1));
                end else if (sub < 90) begin
                    sz = ADDR_BITS'($urandom_range(1024, 1));
                end else if (sub < 93 && heap_limit_reg > heap_brk + HEADER_BYTES) begin
                    sz = ADDR_BITS'(heap_limit_reg - heap_brk - HEADER_BYTES);
                end
                queue_request(ACT_ALLOC, sz, fa);
            end else if (pick < 88 && blk_count != 0) begin
                fa = blk_start[$urandom_range(blk_count - 1, 0)] + HEADER_BYTES;
                queue_request(ACT_FREE, sz, fa);
            end else if (pick < 95) begin
                queue_request(ACT_FREE, sz, fa);
            end else begin
                queue_request(ACT_FREE, sz, '0);
            end
        end
    endtask

    initial begin
        i_clk            = 1'b0;
        i_rst_n          = 1'b0;
        req_ch.valid     = 1'b0;
        req_ch.action    = ACT_ALLOC;
        req_ch.req_bytes = '0;
        req_ch.free_addr = '0;
        rsp_ch.ready     = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        blk_count        = 0;
        heap_brk         = 0;
        heap_limit_reg   = 20'hFFFFF;
        fail_count       = 0;
        results_seen     = 0;
        requests_taken   = 0;
        long_stall_done  = 1'b0;
        quiet_cycles     = 0;
        send_idle        = 27;
        recv_idle        = 64;
        foreach (status_seen[k]) status_seen[k] = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at the reset limit: zero size, null and unknown frees, reuse, overflow.
        queue_request(ACT_ALLOC, 20'd0, 20'hFFFFF);
        queue_request(ACT_FREE, 20'hFFFFF, 20'd0);
        queue_request(ACT_FREE, 20'd0, 20'hFFFFF);
        queue_request(ACT_ALLOC, 20'd1, 20'hFFFFF);
        queue_request(ACT_ALLOC, 20'd100, 20'd0);
        queue_request(ACT_FREE, 20'd0, 20'd16);
        queue_request(ACT_FREE, 20'hFFFFF, 20'd16);
        queue_request(ACT_ALLOC, 20'd1, 20'd0);
        queue_request(ACT_FREE, 20'd0, 20'd33);
        queue_request(ACT_ALLOC, 20'd50, 20'd0);
        queue_request(ACT_ALLOC, 20'd101, 20'd0);
        queue_request(ACT_ALLOC, 20'hFFFFF, 20'd0);
        queue_request(ACT_FREE, 20'd0, 20'd17);
        wait_for_idle();

        // The break now sits at 250; a limit of 300 allows an exact fit of 34 bytes.
        write_heap_limit(20'd300);
        queue_request(ACT_ALLOC, 20'd35, 20'd0);
        queue_request(ACT_ALLOC, 20'd34, 20'd0);
        queue_request(ACT_ALLOC, 20'd1, 20'd0);
        queue_request(ACT_FREE, 20'd0, 20'd266);
        queue_request(ACT_ALLOC, 20'd20, 20'd0);
        wait_for_idle();

        write_heap_limit(20'd3000);
        queue_random_requests(400);
        wait_for_idle();

        send_idle = 64;
        recv_idle = 27;
        write_heap_limit(20'd0);
        queue_random_requests(250);
        wait_for_idle();

        write_heap_limit(20'hFFFFF);
        queue_random_requests(450);
        wait_for_idle();

        send_idle = 0;
        recv_idle = 0;
        write_heap_limit(ADDR_BITS'($urandom_range(20'hFFFFF, heap_brk)));
        queue_random_requests(430);
        wait_for_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Ran %0d requests: %0d ok, %0d zero size, %0d no space, %0d unknown free.",
                 requests_taken, status_seen[ST_OK], status_seen[ST_ZERO],
                 status_seen[ST_NO_SPACE], status_seen[ST_UNKNOWN]);
        $display("Block table ended with %0d of %0d entries and the heap break at %0d.",
                 blk_count, MAX_BLOCKS, heap_brk);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
